FILE: hdl/sbo_pkg.sv
// Shared types and constants for the segment versus obstacle-box checker.
package sbo_pkg;

  // Register indexes on the configuration channel.
  localparam logic [7:0] CFG_OBSTACLE_COUNT = 8'd0;
  localparam logic [7:0] CFG_EPSILON        = 8'd1;

  // Input kind carried on s_tuser.
  localparam logic MODE_BOX_WRITE = 1'b0;
  localparam logic MODE_QUERY     = 1'b1;

  // Digit width of the digit-serial multiplier.
  localparam int DIGIT_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_EVAL,
    ST_PUT
  } state_t;

  typedef enum logic [1:0] {
    KIND_VERTICAL,
    KIND_HORIZONTAL,
    KIND_SLOPE
  } kind_t;

endpackage

FILE: hdl/segment_box_obstacle_check.sv
// Top level of the segment versus obstacle-box clearance checker.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+------------------------------------
//  s_*     | in        | s_tvalid / s_tready | tuser = mode, tdata = slot, box, seg
//  m_*     | out       | m_tvalid / m_tready | tdata = path_free
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A box write is stored straight into the obstacle RAM when it is accepted.
// A query walks the stored boxes one at a time: it reads the entry, then for
// sloped segments takes four products from the digit-serial multiplier (ND
// digits each, ND = ceil((COORD_WIDTH+1)/16)), then evaluates the box. A query
// ends at the first box that blocks, or after the last counted box.
// Reset is synchronous and clears control state only; the RAM holds undefined
// boxes until written. A waiting result does not stop the next item from entering.
module segment_box_obstacle_check #(
  parameter int MAX_OBSTACLES = 64,
  parameter int COORD_WIDTH   = 32
) (
  input  logic         clk,
  input  logic         rst,
  // Input items.
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata from bit 0 up: slot[5:0], box_x_min, box_x_max, box_y_min, box_y_max,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y (32 bits each), 2 zero bits.
  input  logic [263:0] s_tdata,
  // tuser: mode (0 box write, 1 query).
  input  logic         s_tuser,
  // Result items.
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata from bit 0 up: path_free, 7 zero bits.
  output logic [7:0]   m_tdata,
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import sbo_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int D  = CW + 1;
  localparam int PW = 2 * D;
  localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int NW = $clog2(MAX_OBSTACLES + 1);
  localparam int MW = (D > 16) ? D : 16;

  // Configuration registers.
  logic [6:0]  obstacle_count;
  logic [15:0] epsilon;

  // Query state.
  state_t state, state_next;
  kind_t  kind;
  logic [NW-1:0] idx, n;
  logic [1:0]    prod_sel;
  logic signed [CW-1:0] xs, ys, xd, yd;
  logic signed [D-1:0]  dx, dy;
  logic signed [PW-1:0] p_a, p_b, p_c, p_e;
  logic m_free;

  // Datapath signals.
  logic signed [CW-1:0] in_bx0, in_bx1, in_by0, in_by1;
  logic signed [CW-1:0] in_xs, in_ys, in_xd, in_yd;
  logic signed [D-1:0]  in_dx, in_dy;
  logic [MW-1:0]        in_mdx, in_mdy, eps_w;
  kind_t                in_kind;
  logic [NW-1:0]        in_n;
  logic                 accept, box_we;
  logic [AW+5:0]        slot_ext;
  logic [4*CW-1:0]      rd_data;
  logic                 rd_en, mul_start, mul_done;
  logic signed [D-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [CW-1:0] bx0, bx1, by0, by1;
  logic                 hit;
  logic                 last;

  function automatic logic [CW-1:0] to_coord(input logic [31:0] p);
    logic [79:0] e;
    e = {48'd0, p};
    return e[CW-1:0];
  endfunction

  function automatic logic signed [D-1:0] sx(input logic signed [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  function automatic logic [D-1:0] magd(input logic signed [D-1:0] v);
    return v[D-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic ratio_in(input logic signed [PW-1:0] num,
                                    input logic signed [PW-1:0] lo,
                                    input logic signed [PW-1:0] hi,
                                    input logic pos);
    return pos ? (lo <= num && num <= hi) : (lo >= num && num >= hi);
  endfunction

  function automatic logic in_span(input logic signed [CW-1:0] v,
                                   input logic signed [CW-1:0] a,
                                   input logic signed [CW-1:0] b);
    return (v >= a && v <= b) || (v >= b && v <= a);
  endfunction

  function automatic logic ival_hit(input logic signed [CW-1:0] s,
                                    input logic signed [CW-1:0] d,
                                    input logic signed [CW-1:0] lo,
                                    input logic signed [CW-1:0] hi);
    return (s >= lo && s <= hi) || (d >= lo && d <= hi) ||
           (s <= lo && d >= hi) || (d <= lo && s >= hi);
  endfunction

  // Unpack the input item.
  assign in_bx0 = to_coord(s_tdata[37:6]);
  assign in_bx1 = to_coord(s_tdata[69:38]);
  assign in_by0 = to_coord(s_tdata[101:70]);
  assign in_by1 = to_coord(s_tdata[133:102]);
  assign in_xs  = to_coord(s_tdata[165:134]);
  assign in_ys  = to_coord(s_tdata[197:166]);
  assign in_xd  = to_coord(s_tdata[229:198]);
  assign in_yd  = to_coord(s_tdata[261:230]);

  assign in_dx  = sx(in_xd) - sx(in_xs);
  assign in_dy  = sx(in_yd) - sx(in_ys);
  assign in_mdx = MW'(magd(in_dx));
  assign in_mdy = MW'(magd(in_dy));
  assign eps_w  = MW'(epsilon);

  always_comb begin
    if (in_dx == '0 || in_mdx < eps_w) begin
      in_kind = KIND_VERTICAL;
    end else if (in_dy == '0 || in_mdy < eps_w) begin
      in_kind = KIND_HORIZONTAL;
    end else begin
      in_kind = KIND_SLOPE;
    end
  end

  assign in_n = (32'(obstacle_count) > MAX_OBSTACLES) ? NW'(MAX_OBSTACLES)
                                                      : NW'(obstacle_count);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign slot_ext = {AW'(0), s_tdata[5:0]};
  // Writes to slots beyond the table depth are dropped.
  assign box_we   = accept && (s_tuser == MODE_BOX_WRITE) &&
                    (32'(s_tdata[5:0]) < MAX_OBSTACLES);

  sbo_ram #(
    .WIDTH (4 * CW),
    .DEPTH (MAX_OBSTACLES)
  ) u_table (
    .clk     (clk),
    .we      (box_we),
    .wr_addr (slot_ext[AW-1:0]),
    .wr_data ({in_by1, in_by0, in_bx1, in_bx0}),
    .re      (rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  assign bx0 = rd_data[CW-1:0];
  assign bx1 = rd_data[2*CW-1:CW];
  assign by0 = rd_data[3*CW-1:2*CW];
  assign by1 = rd_data[4*CW-1:3*CW];

  // The four cross products shared by all side tests of one box.
  always_comb begin
    unique case (prod_sel)
      2'd0: begin mul_a = sx(by0) - sx(ys); mul_b = dx; end
      2'd1: begin mul_a = sx(by1) - sx(ys); mul_b = dx; end
      2'd2: begin mul_a = sx(bx0) - sx(xs); mul_b = dy; end
      default: begin mul_a = sx(bx1) - sx(xs); mul_b = dy; end
    endcase
  end

  sbo_mul #(
    .OPW (D)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // Box test: endpoint containment, then the test that fits the segment kind.
  always_comb begin
    hit = (xs >= bx0 && xs <= bx1 && ys >= by0 && ys <= by1) ||
          (xd >= bx0 && xd <= bx1 && yd >= by0 && yd <= by1);
    unique case (kind)
      KIND_VERTICAL: begin
        hit = hit || (xd >= bx0 && xd <= bx1 && ival_hit(ys, yd, by0, by1));
      end
      KIND_HORIZONTAL: begin
        hit = hit || (yd >= by0 && yd <= by1 && ival_hit(xs, xd, bx0, bx1));
      end
      default: begin
        hit = hit ||
              (ratio_in(p_c, p_a, p_b, !dx[D-1]) && in_span(bx0, xs, xd)) ||
              (ratio_in(p_e, p_a, p_b, !dx[D-1]) && in_span(bx1, xs, xd)) ||
              (ratio_in(p_a, p_c, p_e, !dy[D-1]) && in_span(by0, ys, yd)) ||
              (ratio_in(p_b, p_c, p_e, !dy[D-1]) && in_span(by1, ys, yd));
      end
    endcase
  end

  assign last = (NW'(idx + 1'b1) == n);

  // Next state and control strobes.
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    mul_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser == MODE_QUERY) begin
          state_next = (in_n == '0) ? ST_PUT : ST_READ;
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = (kind == KIND_SLOPE) ? ST_MUL_GO : ST_EVAL;
      end
      ST_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          state_next = (prod_sel == 2'd3) ? ST_EVAL : ST_MUL_GO;
        end
      end
      ST_EVAL: begin
        state_next = (hit || last) ? ST_PUT : ST_READ;
      end
      ST_PUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Query datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        xs       <= in_xs;
        ys       <= in_ys;
        xd       <= in_xd;
        yd       <= in_yd;
        dx       <= in_dx;
        dy       <= in_dy;
        kind     <= in_kind;
        n        <= in_n;
        idx      <= '0;
        prod_sel <= 2'd0;
        m_free   <= 1'b1;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          unique case (prod_sel)
            2'd0:    p_a <= mul_p;
            2'd1:    p_b <= mul_p;
            2'd2:    p_c <= mul_p;
            default: p_e <= mul_p;
          endcase
          prod_sel <= prod_sel + 2'd1;
        end
      end
      ST_EVAL: begin
        prod_sel <= 2'd0;
        idx      <= idx + 1'b1;
        if (hit) begin
          m_free <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register; a result waits here while the next item may enter.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_PUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {7'd0, m_free};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_count <= 7'd0;
      epsilon        <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_OBSTACLE_COUNT) begin
        obstacle_count <= cfg_data[6:0];
      end else if (cfg_index == CFG_EPSILON) begin
        epsilon <= cfg_data;
      end
    end
  end

endmodule

FILE: hdl/sbo_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sbo_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/sbo_mul.sv
// Digit-serial signed multiplier, one digit of the second operand per cycle.
module sbo_mul #(
  parameter int OPW = 33
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [OPW-1:0]   a,
  input  logic signed [OPW-1:0]   b,
  output logic                    done,
  output logic signed [2*OPW-1:0] prod
);
  import sbo_pkg::*;

  localparam int ND  = (OPW + DIGIT_W - 1) / DIGIT_W;
  localparam int BW  = ND * DIGIT_W;
  localparam int ACW = OPW + BW;
  localparam int PW  = 2 * OPW;
  localparam int CNW = $clog2(ND + 1);

  logic [OPW-1:0]         a_mag;
  logic [BW-1:0]          b_sh;
  logic [ACW-1:0]         acc;
  logic [CNW-1:0]         cnt;
  logic                   run;
  logic                   neg;
  logic [OPW+DIGIT_W-1:0] partial;
  logic [PW-1:0]          mag_out;

  function automatic logic [OPW-1:0] magn(input logic signed [OPW-1:0] v);
    return v[OPW-1] ? (~v + 1'b1) : v;
  endfunction

  assign partial = a_mag * b_sh[BW-1 -: DIGIT_W];
  assign mag_out = acc[PW-1:0];
  assign prod    = neg ? -$signed(mag_out) : $signed(mag_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CNW'(1));
      if (start) begin
        run   <= 1'b1;
        cnt   <= CNW'(ND);
        a_mag <= magn(a);
        b_sh  <= BW'(magn(b));
        acc   <= '0;
        neg   <= a[OPW-1] ^ b[OPW-1];
      end else if (run) begin
        acc  <= (acc << DIGIT_W) + ACW'(partial);
        b_sh <= b_sh << DIGIT_W;
        cnt  <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the segment versus obstacle-box clearance checker.
`timescale 1ns / 100ps

module tb_top;
  import sbo_pkg::*;

  localparam longint UNIT = 65536;          // 1.0 in Q16.16
  localparam logic [7:0] CFG_NO_SUCH_REG = 8'd2;
  localparam int TABLE_DEPTH = 64;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic         mode;
    logic [263:0] payload;
  } item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [263:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  // Predictor state: the obstacle table and both registers as the block holds them.
  longint box_x0 [TABLE_DEPTH];
  longint box_x1 [TABLE_DEPTH];
  longint box_y0 [TABLE_DEPTH];
  longint box_y1 [TABLE_DEPTH];
  logic [6:0]  model_count = '0;
  logic [15:0] model_eps = 16'd1;

  item_t item_queue[$];      // items waiting to be offered on the input side
  logic  free_due[$];        // predicted path_free flags, oldest first
  logic  s_taken = 1'b0;     // the offered item was accepted at the last rising edge
  int    send_idle = 0;
  int    recv_idle = 0;
  int    hold_left = 0;      // cycles left in a forced receiver hold-off
  int    errors = 0;

  always #2 clk = ~clk;

  segment_box_obstacle_check u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Exact test lo <= p*q/den <= hi by cross-multiplication; den is never zero here.
  function automatic logic ratio_within(longint lo, longint p, longint q, longint hi,
                                        longint den);
    wide_t num, l, h;
    num = wide_t'(p) * wide_t'(q);
    l   = wide_t'(lo) * wide_t'(den);
    h   = wide_t'(hi) * wide_t'(den);
    if (den > 0) return l <= num && num <= h;
    return l >= num && num >= h;
  endfunction

  function automatic logic in_span(longint v, longint a, longint b);
    return (v >= a && v <= b) || (v >= b && v <= a);
  endfunction

  function automatic logic overlaps(longint s, longint d, longint lo, longint hi);
    return (s >= lo && s <= hi) || (d >= lo && d <= hi) ||
           (s <= lo && d >= hi) || (d <= lo && s >= hi);
  endfunction

  function automatic logic point_in_box(int i, longint x, longint y);
    return x >= box_x0[i] && x <= box_x1[i] && y >= box_y0[i] && y <= box_y1[i];
  endfunction

  // Predicts path_free for one segment against the boxes below the count.
  function automatic logic path_clear(longint xs, longint ys, longint xd, longint yd);
    int     n;
    longint dx, dy, adx, ady;
    kind_t  kind;
    n   = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
    dx  = xd - xs;
    dy  = yd - ys;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    for (int i = 0; i < n; i++) begin
      if (point_in_box(i, xs, ys) || point_in_box(i, xd, yd)) return 1'b0;
    end
    // A zero difference counts as axis-parallel even when the tolerance is zero.
    if (dx == 0 || adx < longint'(model_eps)) kind = KIND_VERTICAL;
    else if (dy == 0 || ady < longint'(model_eps)) kind = KIND_HORIZONTAL;
    else kind = KIND_SLOPE;
    for (int i = 0; i < n; i++) begin
      case (kind)
        KIND_VERTICAL: begin
          if (xd >= box_x0[i] && xd <= box_x1[i] &&
              overlaps(ys, yd, box_y0[i], box_y1[i])) return 1'b0;
        end
        KIND_HORIZONTAL: begin
          if (yd >= box_y0[i] && yd <= box_y1[i] &&
              overlaps(xs, xd, box_x0[i], box_x1[i])) return 1'b0;
        end
        default: begin
          // Crossing of the segment's line with each of the four box sides.
          if (ratio_within(box_y0[i] - ys, dy, box_x0[i] - xs, box_y1[i] - ys, dx) &&
              in_span(box_x0[i], xs, xd)) return 1'b0;
          if (ratio_within(box_y0[i] - ys, dy, box_x1[i] - xs, box_y1[i] - ys, dx) &&
              in_span(box_x1[i], xs, xd)) return 1'b0;
          if (ratio_within(box_x0[i] - xs, dx, box_y0[i] - ys, box_x1[i] - xs, dy) &&
              in_span(box_y0[i], ys, yd)) return 1'b0;
          if (ratio_within(box_x0[i] - xs, dx, box_y1[i] - ys, box_x1[i] - xs, dy) &&
              in_span(box_y1[i], ys, yd)) return 1'b0;
        end
      endcase
    end
    return 1'b1;
  endfunction

  // Fields are packed from bit 0: slot, the four box edges, then the four segment ends.
  function automatic void push_item(logic mode, logic [5:0] slot,
                                    logic [31:0] x0, logic [31:0] x1,
                                    logic [31:0] y0, logic [31:0] y1,
                                    logic [31:0] sx, logic [31:0] sy,
                                    logic [31:0] ex, logic [31:0] ey);
    item_t it;
    it.mode    = mode;
    it.payload = {2'b00, ey, ex, sy, sx, y1, y0, x1, x0, slot};
    item_queue.push_back(it);
  endfunction

  function automatic void push_box(logic [5:0] slot, longint x0, longint x1,
                                   longint y0, longint y1);
    push_item(MODE_BOX_WRITE, slot, 32'(x0), 32'(x1), 32'(y0), 32'(y1),
              $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic void push_segment(longint sx, longint sy, longint ex, longint ey);
    push_item(MODE_QUERY, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
              32'(sx), 32'(sy), 32'(ex), 32'(ey));
  endfunction

  // Mostly coordinates within about 150 units of the origin, so that hits are common,
  // with a share of fully random words to exercise every bit.
  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 99) < 12) return $urandom;
    return 32'($urandom_range(0, 300 * 65536)) - 32'(150 * 65536);
  endfunction

  function automatic void push_random_box();
    logic [31:0] x0, y0, x1, y1, t;
    x0 = pick_coord();
    y0 = pick_coord();
    x1 = x0 + 32'($urandom_range(0, 40 * 65536));
    y1 = y0 + 32'($urandom_range(0, 40 * 65536));
    // Now and then an inverted box, with its minimum edge above its maximum.
    if ($urandom_range(0, 99) < 6) begin
      t = x0; x0 = x1; x1 = t;
    end
    if ($urandom_range(0, 99) < 4) begin
      t = y0; y0 = y1; y1 = t;
    end
    push_item(MODE_BOX_WRITE, 6'($urandom), x0, x1, y0, y1,
              $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic void push_random_segment();
    logic [31:0] sx, sy, ex, ey, delta;
    int pick;
    sx = pick_coord();
    sy = pick_coord();
    ex = pick_coord();
    ey = pick_coord();
    // A difference around the tolerance, including exactly at it, on one axis.
    delta = 32'($urandom_range(0, int'(model_eps) + 1));
    if ($urandom_range(0, 1)) delta = -delta;
    pick = $urandom_range(0, 9);
    if (pick < 3) ex = sx + delta;
    else if (pick < 6) ey = sy + delta;
    push_item(MODE_QUERY, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
              sx, sy, ex, ey);
  endfunction

  // Driver: offers the next pending item at the falling edge, or idles at random.
  always @(negedge clk) begin
    if (!s_tvalid || s_taken) begin
      if (item_queue.size() != 0 && !rst &&
          $urandom_range(0, 99) >= send_idle) begin
        s_tuser  <= item_queue[0].mode;
        s_tdata  <= item_queue[0].payload;
        s_tvalid <= 1'b1;
        void'(item_queue.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    s_taken <= 1'b0;
  end

  // Receiver: random stalls, plus a long forced hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Monitor: records every accepted box write, predicts on every accepted query and checks every result item.
  always @(posedge clk) begin
    logic exp_free;
    if (s_tvalid && s_tready) begin
      s_taken <= 1'b1;
      if (s_tuser == MODE_BOX_WRITE) begin
        box_x0[s_tdata[5:0]] = longint'($signed(s_tdata[37:6]));
        box_x1[s_tdata[5:0]] = longint'($signed(s_tdata[69:38]));
        box_y0[s_tdata[5:0]] = longint'($signed(s_tdata[101:70]));
        box_y1[s_tdata[5:0]] = longint'($signed(s_tdata[133:102]));
      end else begin
        free_due.push_back(path_clear(longint'($signed(s_tdata[165:134])),
                                      longint'($signed(s_tdata[197:166])),
                                      longint'($signed(s_tdata[229:198])),
                                      longint'($signed(s_tdata[261:230]))));
      end
    end
    if (m_tvalid && m_tready) begin
      if (free_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item, path_free=%0b", m_tdata[0]);
      end else begin
        exp_free = free_due.pop_front();
        if (m_tdata[0] !== exp_free) begin
          errors++;
          if (errors <= 10)
            $display("path_free mismatch: expected %0b, got %0b", exp_free, m_tdata[0]);
        end
      end
    end
  end

  // Writes one register; the predictor takes the value at the accepting edge.
  task automatic write_reg(logic [7:0] index, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == CFG_OBSTACLE_COUNT) model_count = value[6:0];
    else if (index == CFG_EPSILON) model_eps = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every item is in and every result is out, then lets a box write
  // that may still be in flight settle before the registers change.
  task automatic drain();
    do @(posedge clk);
    while (item_queue.size() != 0 || s_tvalid || free_due.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int count, int eps, int n_items, int idle_style);
    write_reg(CFG_OBSTACLE_COUNT, 16'(count));
    write_reg(CFG_EPSILON, 16'(eps));
    send_idle = (idle_style == 0) ? 23 : (idle_style == 1) ? 54 : 0;
    recv_idle = (idle_style == 0) ? 54 : (idle_style == 1) ? 23 : 0;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 20) push_random_box();
      else push_random_segment();
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      box_x0[i] = 0; box_x1[i] = 0; box_y0[i] = 0; box_y1[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the whole table first, so no query ever sees an entry never written.
    // Slots 0 to 3 hold fixed boxes for the directed queries.
    push_box(6'd0, 0, 10 * UNIT, 0, 10 * UNIT);
    push_box(6'd1, 20 * UNIT, 30 * UNIT, -5 * UNIT, 5 * UNIT);
    push_box(6'd2, 50 * UNIT, 40 * UNIT, 0, 10 * UNIT);       // inverted in x
    push_box(6'd3, -100 * UNIT, -90 * UNIT, -100 * UNIT, -90 * UNIT);
    for (int i = 4; i < TABLE_DEPTH; i++)
      push_box(6'(i), 1000 * UNIT, 1001 * UNIT, 1000 * UNIT, 1001 * UNIT);
    push_segment(5 * UNIT, 5 * UNIT, 50 * UNIT, 50 * UNIT);  // no boxes counted yet
    drain();

    // Directed queries against the four fixed boxes.
    write_reg(CFG_OBSTACLE_COUNT, 16'd4);
    write_reg(CFG_NO_SUCH_REG, 16'hFFFF);                    // must be ignored
    push_segment(5 * UNIT, 5 * UNIT, 50 * UNIT, 50 * UNIT);  // start inside a box
    push_segment(60 * UNIT, 70 * UNIT, 10 * UNIT, 10 * UNIT);// end on a box corner
    push_segment(25 * UNIT, -20 * UNIT, 25 * UNIT, 20 * UNIT);  // vertical through
    push_segment(15 * UNIT, 0, 35 * UNIT, 0);                // horizontal through
    push_segment(-5 * UNIT, 5 * UNIT, 5 * UNIT, 15 * UNIT);  // slope touching an edge
    push_segment(60 * UNIT, 60 * UNIT, 70 * UNIT, 80 * UNIT);// clear
    push_segment(45 * UNIT, -50 * UNIT, 45 * UNIT, 50 * UNIT);  // only the inverted box
    push_segment(longint'(32'sh8000_0000), longint'(32'sh8000_0000),
                 longint'(32'sh7FFF_FFFF), longint'(32'sh7FFF_FFFF));
    push_segment(longint'(32'sh7FFF_FFFF), longint'(32'sh8000_0000),
                 longint'(32'sh7FFF_FFFF), longint'(32'sh7FFF_FFFF));
    push_segment(longint'(32'sh8000_0000), 3 * UNIT,
                 longint'(32'sh7FFF_FFFF), 3 * UNIT);
    drain();

    // Zero tolerance: exact zero differences still count as axis-parallel.
    write_reg(CFG_EPSILON, 16'd0);
    push_segment(25 * UNIT, -20 * UNIT, 25 * UNIT, 20 * UNIT);
    push_segment(15 * UNIT, 0, 35 * UNIT, 0);
    push_segment(25 * UNIT, -20 * UNIT, 25 * UNIT + 1, 20 * UNIT);
    push_segment(-50 * UNIT, 8 * UNIT, 50 * UNIT, 8 * UNIT + 1);
    drain();

    // Largest tolerance and a count above the table size, which saturates.
    write_reg(CFG_OBSTACLE_COUNT, 16'd127);
    write_reg(CFG_EPSILON, 16'hFFFF);
    push_segment(25 * UNIT, -20 * UNIT, 25 * UNIT + 65534, 20 * UNIT);
    push_segment(1000 * UNIT + 100, 900 * UNIT, 1000 * UNIT + 100, 1100 * UNIT);
    push_segment(-200 * UNIT, -200 * UNIT, 2000 * UNIT, 2000 * UNIT);
    drain();
    write_reg(CFG_OBSTACLE_COUNT, 16'd100);
    push_segment(900 * UNIT, 1000 * UNIT + 5, 1100 * UNIT, 1000 * UNIT + 5);
    drain();

    // Random phases; most keep the count small since each box costs many cycles.
    random_phase(8, 1, 200, 0);
    random_phase(16, 0, 150, 1);
    random_phase(2, 65535, 140, 2);
    random_phase(64, 1000, 40, 2);

    // Long receiver hold-off while the sender keeps offering items.
    write_reg(CFG_OBSTACLE_COUNT, 16'd1);
    write_reg(CFG_EPSILON, 16'd300);
    send_idle = 0;
    recv_idle = 0;
    @(posedge clk);
    hold_left = 600;
    for (int i = 0; i < 60; i++) push_random_segment();
    drain();
    random_phase(5, 300, 30, 2);

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sbo_pkg.sv
hdl/sbo_ram.sv
hdl/sbo_mul.sv
hdl/segment_box_obstacle_check.sv
dv/tb_top.sv
